[hdl/tabulation_hash_32_assert.svh]
// Assertion macros shared by the block.
`ifndef TABULATION_HASH_32_ASSERT_SVH
`define TABULATION_HASH_32_ASSERT_SVH

`define TH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/th32_pkg.sv]
package th32_pkg;

    localparam int BLOCK_WORDS = 256;
    localparam int SLOT_W = $clog2(BLOCK_WORDS);
    localparam int POS_W = 30;
    localparam int TAB_DEPTH = 1024;
    localparam int TAB_AW = 10;

    localparam logic [1:0] MODE_LOAD_MUL = 2'd0;
    localparam logic [1:0] MODE_LOAD_TAB = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_DATA = 2'd3;

    localparam logic [1:0] REG_SEED = 2'd0;
    localparam logic [1:0] REG_COMBINE = 2'd1;
    localparam logic [1:0] REG_TAIL = 2'd2;
    localparam logic [1:0] REG_ENDIAN = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_APPLY,
        ST_FOLD_MUL,
        ST_FOLD_ADD,
        ST_TAIL_LO,
        ST_TAIL,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load_item;
        logic       mul_rd;
        logic       mul_lo;
        logic       mul_hi;
        logic       apply;
        logic       fold_mul;
        logic       fold_add;
        logic       tail_lo;
        logic       tail;
        logic       fin_rd;
        logic [1:0] lane;
        logic       fin_acc;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_block;
        logic block_end;
    } status_t;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

[hdl/th32_if.sv]
interface th32_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [9:0]  table_index;
    logic [63:0] table_value;
    logic [31:0] message_length;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    modport source (output valid, mode, table_index, table_value, message_length,
                    data_word, byte_count, last_word, input ready);
    modport sink (input valid, mode, table_index, table_value, message_length,
                  data_word, byte_count, last_word, output ready);
endinterface

interface th32_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

[hdl/th32_ram.sv]
module th32_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hdl/th32_ctrl.sv]
`include "tabulation_hash_32_assert.svh"

module th32_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          mode,
    input  logic [2:0]          byte_count,
    input  logic                last_word,
    input  logic [31:0]         message_length,
    input  logic                out_ready,
    input  th32_pkg::status_t   status,
    output logic                in_ready,
    output logic                out_valid,
    output th32_pkg::cmd_t      cmd
);
    th32_pkg::state_t state_reg, state_next;
    logic last_reg, last_next;
    logic [1:0] lane_reg, lane_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic out_hold;

    assign in_ready = (state_reg == th32_pkg::ST_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_hold = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= th32_pkg::ST_IDLE;
            last_reg <= 1'b0;
            lane_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            lane_reg <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next = last_reg;
        lane_next = lane_reg;
        case (state_reg)
            th32_pkg::ST_IDLE:
            begin
                lane_next = 2'd0;
                if (accept)
                begin
                    if (mode == th32_pkg::MODE_START)
                    begin
                        if (message_length == 32'd0)
                        begin
                            state_next = th32_pkg::ST_FIN;
                        end
                    end
                    else if (mode == th32_pkg::MODE_DATA)
                    begin
                        last_next = last_word;
                        if (byte_count >= 3'd4)
                        begin
                            state_next = th32_pkg::ST_MUL_RD;
                        end
                        else if (byte_count != 3'd0)
                        begin
                            state_next = th32_pkg::ST_TAIL_LO;
                        end
                        else if (last_word)
                        begin
                            state_next = th32_pkg::ST_FIN;
                        end
                    end
                end
            end
            th32_pkg::ST_MUL_RD: state_next = th32_pkg::ST_MUL_LO;
            th32_pkg::ST_MUL_LO: state_next = th32_pkg::ST_MUL_HI;
            th32_pkg::ST_MUL_HI: state_next = th32_pkg::ST_APPLY;
            th32_pkg::ST_APPLY:
            begin
                if (status.in_block && status.block_end)
                begin
                    state_next = th32_pkg::ST_FOLD_MUL;
                end
                else
                begin
                    state_next = last_reg ? th32_pkg::ST_FIN : th32_pkg::ST_IDLE;
                end
            end
            th32_pkg::ST_FOLD_MUL: state_next = th32_pkg::ST_FOLD_ADD;
            th32_pkg::ST_TAIL_LO: state_next = th32_pkg::ST_TAIL;
            th32_pkg::ST_FOLD_ADD,
            th32_pkg::ST_TAIL:
            begin
                state_next = last_reg ? th32_pkg::ST_FIN : th32_pkg::ST_IDLE;
            end
            th32_pkg::ST_FIN:
            begin
                lane_next = lane_reg + 2'd1;
                if (lane_reg == 2'd3)
                begin
                    state_next = th32_pkg::ST_OUT;
                end
            end
            th32_pkg::ST_OUT:
            begin
                if (!out_hold)
                begin
                    state_next = th32_pkg::ST_IDLE;
                end
            end
            default: state_next = th32_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == th32_pkg::ST_OUT && !out_hold)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.load_item = accept;
        cmd.lane = lane_reg;
        case (state_reg)
            th32_pkg::ST_MUL_RD: cmd.mul_rd = 1'b1;
            th32_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
            th32_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
            th32_pkg::ST_APPLY: cmd.apply = 1'b1;
            th32_pkg::ST_FOLD_MUL: cmd.fold_mul = 1'b1;
            th32_pkg::ST_FOLD_ADD: cmd.fold_add = 1'b1;
            th32_pkg::ST_TAIL_LO: cmd.tail_lo = 1'b1;
            th32_pkg::ST_TAIL: cmd.tail = 1'b1;
            th32_pkg::ST_FIN:
            begin
                cmd.fin_rd = 1'b1;
                cmd.fin_acc = (lane_reg != 2'd0);
            end
            th32_pkg::ST_OUT:
            begin
                cmd.out_load = !out_hold;
            end
            default: cmd = cmd;
        endcase
    end

    `TH_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == th32_pkg::ST_IDLE,
        "ready outside idle")
    `TH_ASSERT_NEXT(a_out_sets, clk, rst_n, state_reg == th32_pkg::ST_OUT && cmd.out_load,
        out_valid_reg, "result not raised")
    `TH_ASSERT_NEXT(a_fin_lane, clk, rst_n,
        state_reg == th32_pkg::ST_FIN && lane_reg == 2'd3, state_reg == th32_pkg::ST_OUT,
        "lookup sequence broken")
endmodule

[hdl/th32_dp.sv]
module th32_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic [1:0]          mode,
    input  logic [9:0]          table_index,
    input  logic [63:0]         table_value,
    input  logic [31:0]         message_length,
    input  logic [31:0]         data_word,
    input  logic [2:0]          byte_count,
    input  th32_pkg::cmd_t      cmd,
    output th32_pkg::status_t   status,
    output logic [31:0]         hash_value
);
    logic [31:0] seed_reg;
    logic [29:0] comb_mul_reg;
    logic [63:0] tail_mul_reg;
    logic        big_endian_reg;

    logic [31:0] running_reg;
    logic [31:0] block_acc_reg;
    logic [th32_pkg::POS_W-1:0] pos_reg;
    logic [th32_pkg::POS_W-1:0] full_words_reg;
    logic [31:0] word_reg;
    logic [2:0]  count_reg;
    logic [63:0] lo_prod_reg;
    logic [31:0] mul_res_reg;
    logic [61:0] fold_reg;
    logic [31:0] tab_acc_reg;
    logic [31:0] hash_reg;

    logic [63:0] mul_rdata;
    logic [31:0] tab_rdata;
    logic mul_we;
    logic tab_we;
    logic [th32_pkg::TAB_AW-1:0] tab_raddr;
    logic [31:0] words;
    logic [31:0] block_val;
    logic [31:0] tail_val;
    logic [31:0] b0, b1, b2;

    assign mul_we = cmd.load_item && mode == th32_pkg::MODE_LOAD_MUL
        && table_index < 10'(th32_pkg::BLOCK_WORDS);
    assign tab_we = cmd.load_item && mode == th32_pkg::MODE_LOAD_TAB;
    assign tab_raddr = {cmd.lane, running_reg[8*cmd.lane +: 8]};

    th32_ram #(.WIDTH(64), .DEPTH(th32_pkg::BLOCK_WORDS)) u_mul_ram (
        .clk(clk), .we(mul_we),
        .waddr(table_index[th32_pkg::SLOT_W-1:0]), .wdata(table_value),
        .re(cmd.mul_rd), .raddr(pos_reg[th32_pkg::SLOT_W-1:0]), .rdata(mul_rdata)
    );

    th32_ram #(.WIDTH(32), .DEPTH(th32_pkg::TAB_DEPTH)) u_tab_ram (
        .clk(clk), .we(tab_we), .waddr(table_index), .wdata(table_value[31:0]),
        .re(cmd.fin_rd), .raddr(tab_raddr), .rdata(tab_rdata)
    );

    assign status.in_block = pos_reg < full_words_reg;
    assign status.block_end = &pos_reg[th32_pkg::SLOT_W-1:0];

    assign words = {2'b00, message_length[31:2]};
    assign block_val = block_acc_reg ^ mul_res_reg;

    always_comb
    begin
        b0 = {24'd0, word_reg[7:0]};
        b1 = {24'd0, word_reg[15:8]};
        b2 = {24'd0, word_reg[23:16]};
        tail_val = 32'd0;
        if (count_reg[1])
        begin
            tail_val = big_endian_reg ? ((b0 << 8) | b1) : (b0 | (b1 << 8));
            if (count_reg[0])
            begin
                tail_val = (tail_val << 8) | b2;
            end
        end
        else if (count_reg[0])
        begin
            tail_val = b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            comb_mul_reg <= '0;
            tail_mul_reg <= '0;
            big_endian_reg <= 1'b0;
            running_reg <= '0;
            block_acc_reg <= '0;
            pos_reg <= '0;
            full_words_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    th32_pkg::REG_SEED: seed_reg <= cfg_data[31:0];
                    th32_pkg::REG_COMBINE: comb_mul_reg <= cfg_data[29:0];
                    th32_pkg::REG_TAIL: tail_mul_reg <= cfg_data;
                    th32_pkg::REG_ENDIAN: big_endian_reg <= cfg_data[0];
                    default: seed_reg <= seed_reg;
                endcase
            end
            if (cmd.load_item && mode == th32_pkg::MODE_START)
            begin
                running_reg <= message_length ^ seed_reg;
                block_acc_reg <= '0;
                pos_reg <= '0;
                full_words_reg <= {words[29:th32_pkg::SLOT_W], {th32_pkg::SLOT_W{1'b0}}};
            end
            if (cmd.apply)
            begin
                pos_reg <= pos_reg + 1'b1;
                if (status.in_block)
                begin
                    block_acc_reg <= block_val;
                end
                else
                begin
                    running_reg <= running_reg ^ mul_res_reg;
                end
            end
            if (cmd.fold_add)
            begin
                running_reg <= {1'b0, fold_reg[30:0]} + {1'b0, fold_reg[61:31]};
                block_acc_reg <= '0;
            end
            if (cmd.tail)
            begin
                running_reg <= running_reg ^ 32'(({32'd0, tail_mul_reg[63:32]}
                    * {32'd0, tail_val}) + {32'd0, lo_prod_reg[63:32]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            word_reg <= big_endian_reg && byte_count >= 3'd4 ? th32_pkg::swap32(data_word)
                : data_word;
            count_reg <= byte_count;
        end
        if (cmd.mul_lo)
        begin
            lo_prod_reg <= {32'd0, mul_rdata[31:0]} * {32'd0, word_reg};
        end
        if (cmd.tail_lo)
        begin
            lo_prod_reg <= {32'd0, tail_mul_reg[31:0]} * {32'd0, tail_val};
        end
        if (cmd.mul_hi)
        begin
            mul_res_reg <= 32'(({32'd0, mul_rdata[63:32]} * {32'd0, word_reg})
                + {32'd0, lo_prod_reg[63:32]});
        end
        if (cmd.fold_mul)
        begin
            fold_reg <= {30'd0, running_reg} * {32'd0, comb_mul_reg}
                + {32'd0, block_acc_reg[31:2]};
        end
        if (cmd.fin_acc)
        begin
            tab_acc_reg <= (cmd.lane == 2'd1 ? 32'd0 : tab_acc_reg) ^ tab_rdata;
        end
        if (cmd.out_load)
        begin
            hash_reg <= big_endian_reg ? th32_pkg::swap32(tab_acc_reg ^ tab_rdata)
                : tab_acc_reg ^ tab_rdata;
        end
    end

    assign hash_value = hash_reg;
endmodule

[hdl/tabulation_hash_32.sv]
// Tabulation hash of a byte message, 32-bit result.
// Input channel in: mode selects multiplier load, tabulation load, start, or
// data word (up to four bytes, byte_count valid, last_word ends the message).
// Output channel out: one hash_value word after each last_word, and after a
// start word of length zero.
// Configuration: cfg_we, cfg_index, cfg_data write seed, combine multiplier,
// tail multiplier and byte order; write only while idle.
// Steps: loads and starts are handled on acceptance; a full data word runs
// a multiplier RAM read, two 32x32 partial products and an apply, plus a
// Mersenne combine (multiply, then add) at each block end; a tail runs two
// partial products of the tail multiplier.
// The final lookup reads the tabulation RAM once per lane, then loads the
// result register and raises out.valid together.
// One word is processed at a time.
// Reset clears the running state and settings; tables hold garbage until
// loaded. While out is stalled the waiting result holds in its register and
// in keeps taking words until the next result is ready, then drops ready.
module tabulation_hash_32 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    th32_in_if.sink       in,
    th32_out_if.source    out
);
    th32_pkg::cmd_t cmd;
    th32_pkg::status_t status;

    th32_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .mode(in.mode),
        .byte_count(in.byte_count), .last_word(in.last_word),
        .message_length(in.message_length), .out_ready(out.ready),
        .status(status), .in_ready(in.ready), .out_valid(out.valid), .cmd(cmd)
    );

    th32_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .mode(in.mode), .table_index(in.table_index),
        .table_value(in.table_value), .message_length(in.message_length),
        .data_word(in.data_word), .byte_count(in.byte_count), .cmd(cmd),
        .status(status), .hash_value(out.hash_value)
    );
endmodule

[tb/tabulation_hash_32_test.sv]
`timescale 1ns / 100ps

module tabulation_hash_32_test;

    typedef struct {
        logic [1:0]  mode;
        logic [9:0]  tidx;
        logic [63:0] tval;
        logic [31:0] mlen;
        logic [31:0] dword;
        logic [2:0]  bcnt;
        logic        last;
    } word_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_index = th32_pkg::REG_SEED;
    logic [63:0] cfg_data = '0;

    th32_in_if in_ch();
    th32_out_if out_ch();

    tabulation_hash_32 dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in(in_ch), .out(out_ch)
    );

    always #5 clk = ~clk;

    word_t pending[$];
    logic [31:0] hash_exp[$];
    int errors = 0;
    bit busy = 0;
    bit quiet = 0;
    bit hold_go = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_cnt = 0;

    logic [63:0] mul_tab[th32_pkg::BLOCK_WORDS];
    logic [31:0] tab_tab[th32_pkg::TAB_DEPTH];
    logic [31:0] run_hash, blk_acc, seed_r;
    logic [29:0] word_pos, full_words, comb_r;
    logic [63:0] tail_r;
    logic        be_r;

    function automatic logic [31:0] mul_shift(logic [63:0] m, logic [31:0] w);
        logic [63:0] p;
        p = m * {32'd0, w};
        return p[63:32];
    endfunction

    function automatic logic [31:0] bswap(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] hash_out();
        logic [31:0] t;
        t = '0;
        for (int lane = 0; lane < 4; lane++)
            t ^= tab_tab[{lane[1:0], run_hash[lane*8 +: 8]}];
        return be_r ? bswap(t) : t;
    endfunction

    task automatic predict(word_t it);
        logic [31:0] w, v, wds, lastv, nxt;
        logic [63:0] t;
        case (it.mode)
            th32_pkg::MODE_LOAD_MUL:
                if (it.tidx < th32_pkg::BLOCK_WORDS) mul_tab[it.tidx[7:0]] = it.tval;
            th32_pkg::MODE_LOAD_TAB: tab_tab[it.tidx] = it.tval[31:0];
            th32_pkg::MODE_START:
            begin
                wds = it.mlen >> 2;
                run_hash = it.mlen ^ seed_r;
                blk_acc = '0;
                word_pos = '0;
                full_words = {wds[29:8], 8'd0};
                if (it.mlen == 0) hash_exp.push_back(hash_out());
            end
            default:
            begin
                if (it.bcnt >= 4)
                begin
                    w = be_r ? bswap(it.dword) : it.dword;
                    v = mul_shift(mul_tab[word_pos[7:0]], w);
                    if (word_pos < full_words)
                    begin
                        blk_acc ^= v;
                        if (word_pos[7:0] == 8'hff)
                        begin
                            t = {32'd0, run_hash} * {34'd0, comb_r} + {32'd0, blk_acc >> 2};
                            run_hash = {1'b0, t[30:0]} + t[62:31];
                            blk_acc = '0;
                        end
                    end
                    else
                        run_hash ^= v;
                    word_pos = word_pos + 30'd1;
                end
                else if (it.bcnt != 0)
                begin
                    lastv = '0;
                    nxt = {24'd0, it.dword[7:0]};
                    if (it.bcnt[1])
                    begin
                        lastv = be_r ? {16'd0, it.dword[7:0], it.dword[15:8]}
                                     : {16'd0, it.dword[15:0]};
                        nxt = {24'd0, it.dword[23:16]};
                    end
                    if (it.bcnt[0]) lastv = (lastv << 8) | nxt;
                    run_hash ^= mul_shift(tail_r, lastv);
                end
                if (it.last) hash_exp.push_back(hash_out());
            end
        endcase
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && !busy)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 0;
            end
            else if (pending.size() > 0)
            begin
                word_t it;
                it = pending.pop_front();
                busy = 1;
                in_ch.valid <= 1;
                in_ch.mode <= it.mode;
                in_ch.table_index <= it.tidx;
                in_ch.table_value <= it.tval;
                in_ch.message_length <= it.mlen;
                in_ch.data_word <= it.dword;
                in_ch.byte_count <= it.bcnt;
                in_ch.last_word <= it.last;
                if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 12);
            end
            else
                in_ch.valid <= 0;
        end
        else if (!rst_n)
            in_ch.valid <= 0;
    end

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && busy)
        begin
            word_t it;
            it.mode = in_ch.mode;
            it.tidx = in_ch.table_index;
            it.tval = in_ch.table_value;
            it.mlen = in_ch.message_length;
            it.dword = in_ch.data_word;
            it.bcnt = in_ch.byte_count;
            it.last = in_ch.last_word;
            predict(it);
            busy = 0;
        end
    end

    // receiver readiness
    always @(negedge clk)
    begin
        if (hold_go)
        begin
            hold_go = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            out_ch.ready <= 0;
        end
        else if (quiet)
            out_ch.ready <= 1;
        else if (recv_gap > 0)
        begin
            recv_gap = recv_gap - 1;
            out_ch.ready <= 0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 11);
            out_ch.ready <= 0;
        end
        else
            out_ch.ready <= 1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (hash_exp.size() == 0)
            begin
                $error("hash_value: no word expected, actual %h", out_ch.hash_value);
                errors++;
            end
            else
            begin
                logic [31:0] e;
                e = hash_exp.pop_front();
                if (out_ch.hash_value !== e)
                begin
                    $error("hash_value: expected %h actual %h", e, out_ch.hash_value);
                    errors++;
                end
            end
        end
    end

    function automatic word_t mk(logic [1:0] mode, logic [31:0] tidx, logic [63:0] tval,
                                 logic [31:0] mlen, logic [31:0] dword,
                                 logic [31:0] bcnt, logic [31:0] last);
        word_t it;
        it.mode = mode; it.tidx = tidx[9:0]; it.tval = tval; it.mlen = mlen;
        it.dword = dword; it.bcnt = bcnt[2:0]; it.last = last[0];
        return it;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_msg(logic [31:0] len);
        int nw;
        nw = len >> 2;
        pending.push_back(mk(th32_pkg::MODE_START, $urandom, rnd64(), len, $urandom,
                             $urandom, $urandom));
        for (int i = 0; i < nw; i++)
            pending.push_back(mk(th32_pkg::MODE_DATA, $urandom, rnd64(), $urandom, $urandom,
                                 4, ((i == nw - 1) && (len[1:0] == 2'd0)) ? 1 : 0));
        if (len[1:0] != 0)
            pending.push_back(mk(th32_pkg::MODE_DATA, $urandom, rnd64(), $urandom, $urandom,
                                 {30'd0, len[1:0]}, 1));
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 4))
            0: pending.push_back(mk(th32_pkg::MODE_LOAD_MUL, $urandom, rnd64(), $urandom,
                                    $urandom, $urandom, $urandom));
            1: pending.push_back(mk(th32_pkg::MODE_LOAD_TAB, $urandom, rnd64(), $urandom,
                                    $urandom, $urandom, $urandom));
            2: pending.push_back(mk(th32_pkg::MODE_START, $urandom, rnd64(), $urandom,
                                    $urandom, $urandom, $urandom));
            default: pending.push_back(mk(th32_pkg::MODE_DATA, $urandom, rnd64(), $urandom,
                                          $urandom, $urandom, $urandom));
        endcase
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            th32_pkg::REG_SEED: seed_r = val[31:0];
            th32_pkg::REG_COMBINE: comb_r = val[29:0];
            th32_pkg::REG_TAIL: tail_r = val;
            default: be_r = val[0];
        endcase
    endtask

    task automatic drain();
        while (pending.size() != 0 || busy || hash_exp.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic random_phase(int n);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                push_noise();
                cnt++;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: len = $urandom_range(65, 120);
                    default: len = $urandom_range(0, 64);
                endcase
                push_msg(len);
                cnt += 1 + len / 4 + (len % 4 != 0);
            end
            while (pending.size() >= 64)
                @(negedge clk);
        end
    endtask

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.mode = th32_pkg::MODE_LOAD_MUL;
        in_ch.table_index = '0;
        in_ch.table_value = '0;
        in_ch.message_length = '0;
        in_ch.data_word = '0;
        in_ch.byte_count = '0;
        in_ch.last_word = 0;
        out_ch.ready = 0;
        run_hash = '0; blk_acc = '0; word_pos = '0; full_words = '0;
        seed_r = '0; comb_r = '0; tail_r = '0; be_r = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_reg(th32_pkg::REG_SEED, 64'd0);
        write_reg(th32_pkg::REG_COMBINE, 64'd0);
        write_reg(th32_pkg::REG_TAIL, 64'd0);
        write_reg(th32_pkg::REG_ENDIAN, 64'd0);
        for (int i = 0; i < th32_pkg::BLOCK_WORDS; i++)
            pending.push_back(mk(th32_pkg::MODE_LOAD_MUL, i, rnd64(), 0, 0, 0, 0));
        for (int i = 0; i < th32_pkg::TAB_DEPTH; i++)
            pending.push_back(mk(th32_pkg::MODE_LOAD_TAB, i, rnd64(), 0, 0, 0, 0));

        // directed
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'hffffffff, 4, 1));
        pending.push_back(mk(th32_pkg::MODE_START, 0, 64'd0, 0, 0, 0, 0));
        pending.push_back(mk(th32_pkg::MODE_LOAD_MUL, 256, '1, 0, 0, 0, 0));
        pending.push_back(mk(th32_pkg::MODE_LOAD_MUL, 1023, '1, 0, 0, 0, 0));
        pending.push_back(mk(th32_pkg::MODE_LOAD_MUL, 255, '1, 0, 0, 0, 0));
        pending.push_back(mk(th32_pkg::MODE_LOAD_TAB, 1023, '1, 0, 0, 0, 0));
        pending.push_back(mk(th32_pkg::MODE_START, '1, '1, 32'hffffffff, '1, '1, 1));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'hffffffff, 7, 0));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'h12345678, 5, 0));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'hffffffff, 0, 1));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'h0, 4, 1));
        pending.push_back(mk(th32_pkg::MODE_START, 0, 64'd0, 7, 0, 0, 0));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'hdeadbeef, 4, 0));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'hffffff, 3, 1));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'hffff, 2, 1));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'hff, 1, 1));
        pending.push_back(mk(th32_pkg::MODE_DATA, 0, 64'd0, 0, 32'h0, 0, 0));
        drain();

        write_reg(th32_pkg::REG_SEED, 64'hffffffff);
        write_reg(th32_pkg::REG_COMBINE, 64'h3fffffff);
        write_reg(th32_pkg::REG_TAIL, '1);
        write_reg(th32_pkg::REG_ENDIAN, 64'd1);
        push_msg(1027);
        push_msg(3);
        push_msg(2);
        push_msg(1);
        drain();

        // hold the receiver while short messages pile up
        write_reg(th32_pkg::REG_SEED, {32'd0, $urandom});
        write_reg(th32_pkg::REG_COMBINE, {32'd0, $urandom_range(0, 32'h3fffffff)});
        write_reg(th32_pkg::REG_TAIL, rnd64());
        write_reg(th32_pkg::REG_ENDIAN, 64'd0);
        hold_go = 1;
        for (int i = 0; i < 20; i++)
            push_msg($urandom_range(0, 6));
        random_phase(20);
        drain();

        for (int p = 0; p < 2; p++)
        begin
            write_reg(th32_pkg::REG_SEED, {32'd0, $urandom});
            write_reg(th32_pkg::REG_COMBINE, {32'd0, $urandom_range(0, 32'h3fffffff)});
            write_reg(th32_pkg::REG_TAIL, rnd64());
            write_reg(th32_pkg::REG_ENDIAN, {63'd0, 1'($urandom_range(0, 1))});
            random_phase(20);
            drain();
        end

        write_reg(th32_pkg::REG_SEED, 64'd0);
        write_reg(th32_pkg::REG_COMBINE, 64'd1);
        write_reg(th32_pkg::REG_TAIL, 64'd1);
        write_reg(th32_pkg::REG_ENDIAN, 64'd1);
        quiet = 1;
        random_phase(20);
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
